FILE: rtl/decimating_fir_with_interpolation_assert.svh
// Assertion macros used by the port-level checker of the decimating FIR.
`ifndef DECIMATING_FIR_WITH_INTERPOLATION_ASSERT_SVH
`define DECIMATING_FIR_WITH_INTERPOLATION_ASSERT_SVH

// Consequent must hold in the clock after the antecedent.
`define DFI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define DFI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dfi_pkg.sv
// Package with widths, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package dfi_pkg;

    localparam int MAX_TAPS_DEF   = 32;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_IDX_BITS  = 5;
    localparam int SUM_BITS       = 32;
    localparam int RATIO_BITS     = 8;
    localparam int TAPCNT_BITS    = 6;
    localparam int CFG_IDX_BITS   = 1;
    localparam int DVD_BITS       = 34;
    localparam int ACC_BITS       = 48;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;

    localparam logic [TAPCNT_BITS-1:0] TAP_COUNT_RST   = 6'd13;
    localparam logic [RATIO_BITS-1:0]  DECIM_RATIO_RST = 8'd10;

    localparam logic [1:0] MODE_FILTER = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECIM_RATIO = 1'b1;

    typedef struct packed {
        logic accept_filter;
        logic accept_coef;
        logic accept_flush;
        logic mult;
        logic div_start;
        logic div_sel_avg;
        logic res_interp;
        logic ring_wr;
        logic fir_start;
        logic fir_end;
        logic flush_step;
        logic out_load;
    } dfi_cmd_t;

    typedef struct packed {
        logic decim;
        logic div_busy;
        logic fir_busy;
        logic flush_last;
        logic out_busy;
    } dfi_sts_t;

endpackage

FILE: rtl/dfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dfi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/dfi_ctrl.sv
// Controller state machine that sequences each word through the datapath.
`timescale 1ns / 1ps
module dfi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  dfi_pkg::dfi_sts_t sts,
    output dfi_pkg::dfi_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_CHECK    = 10'b00_0000_0010,
        ST_MULT     = 10'b00_0000_0100,
        ST_DIV_INT  = 10'b00_0000_1000,
        ST_DIV_AVG  = 10'b00_0001_0000,
        ST_FIR_LOAD = 10'b00_0010_0000,
        ST_FIR      = 10'b00_0100_0000,
        ST_RESULT   = 10'b00_1000_0000,
        ST_FLUSH    = 10'b01_0000_0000,
        ST_SPARE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        dfi_pkg::MODE_FILTER:
                        begin
                            cmd.accept_filter = 1'b1;
                            state_next        = ST_CHECK;
                        end
                        dfi_pkg::MODE_COEF:
                        begin
                            cmd.accept_coef = 1'b1;
                        end
                        dfi_pkg::MODE_FLUSH:
                        begin
                            cmd.accept_flush = 1'b1;
                            state_next       = ST_FLUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (sts.decim)
                begin
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_avg = 1'b1;
                    state_next      = ST_DIV_AVG;
                end
                else
                begin
                    cmd.mult   = 1'b1;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_INT;
            end
            ST_DIV_INT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.res_interp = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_DIV_AVG:
            begin
                if (!sts.div_busy)
                begin
                    cmd.ring_wr = 1'b1;
                    state_next  = ST_FIR_LOAD;
                end
            end
            ST_FIR_LOAD:
            begin
                cmd.fir_start = 1'b1;
                state_next    = ST_FIR;
            end
            ST_FIR:
            begin
                if (!sts.fir_busy)
                begin
                    cmd.fir_end = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush_step = 1'b1;
                if (sts.flush_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/dfi_datapath.sv
// Datapath: block sum, shared divider, sample ring, tap MAC and output register.
`timescale 1ns / 1ps
module dfi_datapath #(
    parameter int MAX_TAPS = dfi_pkg::MAX_TAPS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  dfi_pkg::dfi_cmd_t                         cmd,
    output dfi_pkg::dfi_sts_t                         sts,
    input  logic                                      cfg_we,
    input  logic [dfi_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [dfi_pkg::RATIO_BITS-1:0]            cfg_data,
    input  logic signed [dfi_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic [dfi_pkg::COEF_IDX_BITS-1:0]         coef_index,
    input  logic signed [dfi_pkg::COEF_BITS-1:0]      coef_value,
    input  logic signed [dfi_pkg::SAMPLE_BITS-1:0]    fill_value,
    output logic signed [dfi_pkg::SAMPLE_BITS-1:0]    filtered,
    output logic                                      decimated_now,
    output logic                                      out_valid,
    input  logic                                      out_ready
);

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_W  = $clog2(MAX_TAPS + 1);
    localparam int SB     = dfi_pkg::SAMPLE_BITS;
    localparam int CB     = dfi_pkg::COEF_BITS;
    localparam int DW     = dfi_pkg::DVD_BITS;
    localparam int AW     = dfi_pkg::ACC_BITS;
    localparam int PW     = dfi_pkg::PROD_BITS;
    localparam int RB     = dfi_pkg::RATIO_BITS;
    localparam int CNT_W  = $clog2(DW + 1);

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'((48'sd1 <<< (SB - 1)) - 48'sd1);
        lo = -hi - AW'(48'sd1);
        if (v > hi)
        begin
            sat_sample = SB'(hi);
        end
        else if (v < lo)
        begin
            sat_sample = SB'(lo);
        end
        else
        begin
            sat_sample = SB'(v);
        end
    endfunction

    logic [dfi_pkg::TAPCNT_BITS-1:0] tap_count_reg;
    logic [RB-1:0]                   decim_ratio_reg;
    logic signed [dfi_pkg::SUM_BITS-1:0] sum_reg;
    logic [RB-1:0]                   count_reg;
    logic [ADDR_W-1:0]               wpos_reg;
    logic signed [SB-1:0]            newest_reg;
    logic signed [SB-1:0]            prev_reg;
    logic signed [SB-1:0]            fill_reg;
    logic [MAX_TAPS-1:0]             ring_vld_reg;
    logic signed [DW-1:0]            ip_reg;
    logic [DW-1:0]                   dvd_reg;
    logic [RB-1:0]                   rem_reg;
    logic                            neg_reg;
    logic [CNT_W-1:0]                div_cnt_reg;
    logic                            div_busy_reg;
    logic [ADDR_W-1:0]               k_reg;
    logic [ADDR_W-1:0]               p_reg;
    logic [ADDR_W-1:0]               fk_reg;
    logic                            issue_reg;
    logic                            s1_reg;
    logic                            s2_reg;
    logic                            vld1_reg;
    logic signed [PW-1:0]            prod_reg;
    logic signed [AW-1:0]            acc_reg;
    logic signed [SB-1:0]            res_reg;
    logic                            res_dec_reg;
    logic signed [SB-1:0]            out_reg;
    logic                            out_dec_reg;
    logic                            out_valid_reg;

    logic [TAP_W-1:0]      taps;
    logic [ADDR_W-1:0]     last_a;
    logic [RB-1:0]         ratio;
    logic signed [SB:0]    diff;
    logic signed [RB:0]    cnt_s;
    logic signed [DW-1:0]  ip_prod;
    logic signed [DW-1:0]  div_src;
    logic [RB:0]           rem_sh;
    logic                  q_bit;
    logic [RB:0]           rem_sub;
    logic signed [DW-1:0]  quot;
    logic signed [SB-1:0]  avg_sat;
    logic signed [AW-1:0]  acc_rnd;
    logic signed [AW-1:0]  acc_shr;
    logic                  ring_we;
    logic [ADDR_W-1:0]     ring_waddr;
    logic signed [SB-1:0]  ring_wdata;
    logic [SB-1:0]         ring_rdata;
    logic                  coef_we;
    logic [8:0]            coef_idx_ext;
    logic [CB-1:0]         coef_rdata;
    logic signed [SB-1:0]  ring_sample;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = TAP_W'(1);
        end
        else if (9'(tap_count_reg) > 9'(MAX_TAPS))
        begin
            taps = TAP_W'(MAX_TAPS);
        end
        else
        begin
            taps = TAP_W'(tap_count_reg);
        end
    end

    assign last_a = ADDR_W'(taps - TAP_W'(1));
    assign ratio  = (decim_ratio_reg == '0) ? RB'(1) : decim_ratio_reg;

    assign diff    = (SB + 1)'(newest_reg) - (SB + 1)'(prev_reg);
    assign cnt_s   = $signed({1'b0, count_reg});
    assign ip_prod = diff * cnt_s;

    assign div_src = cmd.div_sel_avg ? DW'(sum_reg) : ip_reg;
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign q_bit   = (rem_sh >= {1'b0, ratio});
    assign rem_sub = q_bit ? (rem_sh - {1'b0, ratio}) : rem_sh;
    assign quot    = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
    assign avg_sat = sat_sample(AW'(quot));

    assign acc_rnd = acc_reg + AW'(48'sd1 <<< (dfi_pkg::COEF_FRAC_BITS - 1));
    assign acc_shr = acc_rnd >>> dfi_pkg::COEF_FRAC_BITS;

    assign ring_we    = cmd.ring_wr || cmd.flush_step;
    assign ring_waddr = cmd.flush_step ? fk_reg : wpos_reg;
    assign ring_wdata = cmd.flush_step ? fill_reg : avg_sat;

    assign coef_idx_ext = 9'(coef_index);
    assign coef_we      = cmd.accept_coef && (coef_idx_ext < 9'(MAX_TAPS));

    assign ring_sample = vld1_reg ? $signed(ring_rdata) : '0;

    dfi_ram #(
        .WIDTH(SB),
        .DEPTH(MAX_TAPS)
    ) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(ring_wdata),
        .raddr(p_reg),
        .rdata(ring_rdata)
    );

    dfi_ram #(
        .WIDTH(CB),
        .DEPTH(MAX_TAPS)
    ) u_coef (
        .clk  (clk),
        .we   (coef_we),
        .waddr(coef_idx_ext[ADDR_W-1:0]),
        .wdata(coef_value),
        .raddr(k_reg),
        .rdata(coef_rdata)
    );

    assign sts.decim      = (count_reg == '0) || (count_reg >= ratio);
    assign sts.div_busy   = div_busy_reg;
    assign sts.fir_busy   = issue_reg || s1_reg || s2_reg;
    assign sts.flush_last = (fk_reg == last_a);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign filtered      = out_reg;
    assign decimated_now = out_dec_reg;
    assign out_valid     = out_valid_reg;

    // Control state: configuration, block state, sequencing flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg   <= dfi_pkg::TAP_COUNT_RST;
            decim_ratio_reg <= dfi_pkg::DECIM_RATIO_RST;
            sum_reg         <= '0;
            count_reg       <= '0;
            wpos_reg        <= '0;
            newest_reg      <= '0;
            prev_reg        <= '0;
            ring_vld_reg    <= '0;
            div_busy_reg    <= 1'b0;
            div_cnt_reg     <= '0;
            issue_reg       <= 1'b0;
            s1_reg          <= 1'b0;
            s2_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dfi_pkg::REG_TAP_COUNT:
                    begin
                        tap_count_reg <= cfg_data[dfi_pkg::TAPCNT_BITS-1:0];
                    end
                    dfi_pkg::REG_DECIM_RATIO:
                    begin
                        decim_ratio_reg <= cfg_data;
                    end
                    default:
                    begin
                        decim_ratio_reg <= decim_ratio_reg;
                    end
                endcase
            end

            if (cmd.accept_filter)
            begin
                sum_reg   <= sum_reg + dfi_pkg::SUM_BITS'(sample);
                count_reg <= count_reg + RB'(1);
            end
            else if (cmd.accept_flush)
            begin
                sum_reg    <= '0;
                count_reg  <= '0;
                newest_reg <= fill_value;
                prev_reg   <= fill_value;
            end
            else if (cmd.fir_end)
            begin
                sum_reg    <= '0;
                count_reg  <= '0;
                prev_reg   <= newest_reg;
                newest_reg <= sat_sample(acc_shr);
                if (9'(wpos_reg) >= 9'(last_a))
                begin
                    wpos_reg <= '0;
                end
                else
                begin
                    wpos_reg <= wpos_reg + ADDR_W'(1);
                end
            end

            if (ring_we)
            begin
                ring_vld_reg[ring_waddr] <= 1'b1;
            end

            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= CNT_W'(DW);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end

            if (cmd.fir_start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && (k_reg == last_a))
            begin
                issue_reg <= 1'b0;
            end
            s1_reg <= issue_reg;
            s2_reg <= s1_reg;

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_flush)
        begin
            fill_reg <= fill_value;
            fk_reg   <= '0;
        end
        else if (cmd.flush_step)
        begin
            fk_reg <= fk_reg + ADDR_W'(1);
        end

        if (cmd.mult)
        begin
            ip_reg <= ip_prod;
        end

        if (cmd.div_start)
        begin
            neg_reg <= div_src[DW-1];
            dvd_reg <= div_src[DW-1] ? DW'(-div_src) : DW'(div_src);
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= rem_sub[RB-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], q_bit};
        end

        if (cmd.fir_start)
        begin
            k_reg   <= '0;
            p_reg   <= wpos_reg;
            acc_reg <= '0;
        end
        else
        begin
            if (issue_reg)
            begin
                k_reg <= k_reg + ADDR_W'(1);
                p_reg <= (p_reg == '0) ? last_a : (p_reg - ADDR_W'(1));
            end
            if (s2_reg)
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
        end
        vld1_reg <= ring_vld_reg[p_reg];
        prod_reg <= ring_sample * $signed(coef_rdata);

        if (cmd.res_interp)
        begin
            res_reg     <= prev_reg + quot[SB-1:0];
            res_dec_reg <= 1'b0;
        end
        else if (cmd.fir_end)
        begin
            res_reg     <= newest_reg;
            res_dec_reg <= 1'b1;
        end

        if (cmd.out_load)
        begin
            out_reg     <= res_reg;
            out_dec_reg <= res_dec_reg;
        end
    end

endmodule

FILE: rtl/decimating_fir_with_interpolation.sv
// Top level of the decimating boxcar FIR with linear output interpolation.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_ready   mode, sample, coef_index, coef_value, fill_value
//   out       out_valid / out_ready filtered, decimated_now
//   cfg       cfg_we                cfg_index, cfg_data
//
// A coefficient word is written without leaving idle; a flush writes the fill value into each active ring entry.
// An interpolated sample passes through the 34-step divider, and a block-completing sample
// through the 34-step divider and then the one-tap-per-cycle MAC.
// Reset clears the ring through per-entry valid flags, so no clearing pass is needed.
// A stalled output word waits in the output register while the next word is taken.
`timescale 1ns / 1ps
module decimating_fir_with_interpolation #(
    parameter int MAX_TAPS = dfi_pkg::MAX_TAPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             mode,
    input  logic signed [dfi_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [dfi_pkg::COEF_IDX_BITS-1:0]      coef_index,
    input  logic signed [dfi_pkg::COEF_BITS-1:0]   coef_value,
    input  logic signed [dfi_pkg::SAMPLE_BITS-1:0] fill_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [dfi_pkg::SAMPLE_BITS-1:0] filtered,
    output logic                                   decimated_now,
    input  logic                                   cfg_we,
    input  logic [dfi_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [dfi_pkg::RATIO_BITS-1:0]         cfg_data
);

    dfi_pkg::dfi_cmd_t cmd;
    dfi_pkg::dfi_sts_t sts;

    dfi_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode    (mode),
        .sts     (sts),
        .cmd     (cmd)
    );

    dfi_datapath #(
        .MAX_TAPS(MAX_TAPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .fill_value   (fill_value),
        .filtered     (filtered),
        .decimated_now(decimated_now),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule

FILE: rtl/dfi_checker.sv
// Port-level checker for the decimating FIR, bound to the top level.
`timescale 1ns / 1ps
`include "decimating_fir_with_interpolation_assert.svh"
module dfi_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic [1:0]                             mode,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [dfi_pkg::SAMPLE_BITS-1:0] filtered
);

    `DFI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "Output word dropped while stalled")
    `DFI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(filtered), "Output word changed while stalled")
    `DFI_ASSERT_NEXT(a_no_result, !out_valid && in_valid && in_ready && (mode != dfi_pkg::MODE_FILTER), !out_valid, "Result from a word that makes none")
    `DFI_ASSERT_SAME(a_load_busy, $rose(out_valid), $past(!in_ready), "Result loaded while input side was idle")

endmodule

bind decimating_fir_with_interpolation dfi_checker u_dfi_checker (.*);

FILE: sim/decimating_fir_with_interpolation_checker.sv
// Checker that predicts the decimating FIR outputs and compares them word by word.
`timescale 1ns / 1ps
module decimating_fir_with_interpolation_checker
    import dfi_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [COEF_IDX_BITS-1:0]      coef_index,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    input  logic signed [SAMPLE_BITS-1:0] fill_value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [SAMPLE_BITS-1:0] filtered,
    input  logic                          decimated_now,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [RATIO_BITS-1:0]         cfg_data,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] level;
        logic                          block_done;
    } fir_word_t;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    fir_word_t                     expected_words[$];
    logic signed [SAMPLE_BITS-1:0] ring[MAX_TAPS_DEF];
    logic signed [COEF_BITS-1:0]   coefs[MAX_TAPS_DEF];
    logic [COEF_IDX_BITS-1:0]      wr_pos;
    logic signed [SUM_BITS-1:0]    acc_sum;
    logic [RATIO_BITS-1:0]         acc_count;
    logic signed [SAMPLE_BITS-1:0] newest_level;
    logic signed [SAMPLE_BITS-1:0] prior_level;
    logic [TAPCNT_BITS-1:0]        taps_reg;
    logic [RATIO_BITS-1:0]         ratio_reg;

    function automatic longint clip_sample(longint v);
        if (v > SAT_HI)
        begin
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            return SAT_LO;
        end
        return v;
    endfunction

    task automatic filter_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int        taps;
        int        ratio;
        int        p;
        longint    acc;
        longint    q;
        fir_word_t w;
        taps  = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS_DEF) ? MAX_TAPS_DEF : taps_reg;
        ratio = (ratio_reg == 0) ? 1 : ratio_reg;
        acc_sum   = acc_sum + SUM_BITS'(x);
        acc_count = acc_count + 1'b1;
        if (acc_count != 0 && acc_count < ratio)
        begin
            q = ((longint'(newest_level) - longint'(prior_level)) * longint'(acc_count))
                / longint'(ratio);
            w.level      = SAMPLE_BITS'(longint'(prior_level) + q);
            w.block_done = 1'b0;
        end
        else
        begin
            prior_level = newest_level;
            ring[wr_pos] = SAMPLE_BITS'(clip_sample(longint'(acc_sum) / longint'(ratio)));
            acc = 0;
            p = wr_pos;
            for (int k = 0; k < taps; k++)
            begin
                acc += longint'(ring[p]) * longint'(coefs[k]);
                p = (p == 0) ? taps - 1 : p - 1;
            end
            acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
            newest_level = SAMPLE_BITS'(clip_sample(acc >>> COEF_FRAC_BITS));
            wr_pos = (wr_pos >= taps - 1) ? '0 : wr_pos + 1'b1;
            acc_sum   = '0;
            acc_count = '0;
            w.level      = prior_level;
            w.block_done = 1'b1;
        end
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            for (int i = 0; i < MAX_TAPS_DEF; i++)
            begin
                ring[i]  = '0;
                coefs[i] = '0;
            end
            wr_pos       = '0;
            acc_sum      = '0;
            acc_count    = '0;
            newest_level = '0;
            prior_level  = '0;
            taps_reg     = TAP_COUNT_RST;
            ratio_reg    = DECIM_RATIO_RST;
            fail_count   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word: filtered %0d decimated_now %0b",
                           filtered, decimated_now);
                    fail_count++;
                end
                else
                begin
                    fir_word_t w;
                    w = expected_words.pop_front();
                    if (filtered !== w.level)
                    begin
                        $error("filtered: expected %0d, actual %0d", w.level, filtered);
                        fail_count++;
                    end
                    if (decimated_now !== w.block_done)
                    begin
                        $error("decimated_now: expected %0b, actual %0b",
                               w.block_done, decimated_now);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_TAP_COUNT)
                begin
                    taps_reg = cfg_data[TAPCNT_BITS-1:0];
                end
                else if (cfg_index == REG_DECIM_RATIO)
                begin
                    ratio_reg = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_FILTER)
                begin
                    filter_sample(sample);
                end
                else if (mode == MODE_COEF)
                begin
                    coefs[coef_index] = coef_value;
                end
                else if (mode == MODE_FLUSH)
                begin
                    int taps;
                    taps = (taps_reg == 0) ? 1 :
                           (taps_reg > MAX_TAPS_DEF) ? MAX_TAPS_DEF : taps_reg;
                    for (int i = 0; i < taps; i++)
                    begin
                        ring[i] = fill_value;
                    end
                    newest_level = fill_value;
                    prior_level  = fill_value;
                    acc_sum      = '0;
                    acc_count    = '0;
                end
            end
        end
    end

    assign pending = expected_words.size();

endmodule

FILE: sim/decimating_fir_with_interpolation_test.sv
// Testbench top: stimulus, output back-pressure and the final verdict for the decimating FIR.
`timescale 1ns / 1ps
module decimating_fir_with_interpolation_test;
    import dfi_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         SETTLE      = 120;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    mode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [COEF_IDX_BITS-1:0]      coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] fill_value;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          decimated_now;
    logic                          cfg_we;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [RATIO_BITS-1:0]         cfg_data;
    int                            fail_count;
    int                            pending;
    bit                            calm;
    bit                            hold_req;
    int                            cycles;

    decimating_fir_with_interpolation u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .sample(sample), .coef_index(coef_index), .coef_value(coef_value),
        .fill_value(fill_value), .out_valid(out_valid), .out_ready(out_ready),
        .filtered(filtered), .decimated_now(decimated_now), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    decimating_fir_with_interpolation_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .sample(sample), .coef_index(coef_index), .coef_value(coef_value),
        .fill_value(fill_value), .out_valid(out_valid), .out_ready(out_ready),
        .filtered(filtered), .decimated_now(decimated_now), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("** decimating_fir_with_interpolation: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                for (int n = 0; n < 900; n++)
                begin
                    @(posedge clk);
                end
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [1:0] m, input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [COEF_IDX_BITS-1:0] ci,
                             input logic signed [COEF_BITS-1:0] cv,
                             input logic signed [SAMPLE_BITS-1:0] fv);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        sample     <= s;
        coef_index <= ci;
        coef_value <= cv;
        fill_value <= fv;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [RATIO_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic random_words(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                send_word(MODE_FILTER, pick_sample(), COEF_IDX_BITS'($urandom),
                          COEF_BITS'($urandom), SAMPLE_BITS'($urandom));
            end
            else if (pick < 94)
            begin
                send_word(MODE_COEF, SAMPLE_BITS'($urandom), COEF_IDX_BITS'($urandom),
                          COEF_BITS'($urandom), SAMPLE_BITS'($urandom));
            end
            else if (pick < 97)
            begin
                send_word(MODE_FLUSH, SAMPLE_BITS'($urandom), COEF_IDX_BITS'($urandom),
                          COEF_BITS'($urandom), pick_sample());
            end
            else
            begin
                send_word(MODE_UNUSED, SAMPLE_BITS'($urandom), COEF_IDX_BITS'($urandom),
                          COEF_BITS'($urandom), SAMPLE_BITS'($urandom));
            end
        end
    endtask

    initial
    begin
        int taps_set[6]  = '{5, 1, 32, 0, 63, 20};
        int ratio_set[6] = '{3, 1, 255, 0, 7, 2};
        int words_set[6] = '{120, 100, 300, 80, 120, 120};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_FILTER;
        sample     = '0;
        coef_index = '0;
        coef_value = '0;
        fill_value = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_TAP_COUNT;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every coefficient is loaded before the first sample reaches the filter.
        for (int i = 0; i < MAX_TAPS_DEF; i++)
        begin
            send_word(MODE_COEF, '0, COEF_IDX_BITS'(i),
                      (i == 0) ? {1'b0, {(COEF_BITS-1){1'b1}}} :
                      (i == 1) ? {1'b1, {(COEF_BITS-1){1'b0}}} : COEF_BITS'($urandom), '0);
        end
        for (int i = 0; i < 12; i++)
        begin
            send_word(MODE_FILTER, (i % 2) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                      {1'b0, {(SAMPLE_BITS-1){1'b1}}}, '0, '0, '0);
        end
        send_word(MODE_FLUSH, '0, '0, '0, {1'b1, {(SAMPLE_BITS-1){1'b0}}});
        send_word(MODE_UNUSED, '1, '1, '1, '1);
        send_word(MODE_COEF, '0, '1, {1'b1, {(COEF_BITS-1){1'b0}}}, '0);
        for (int i = 0; i < 6; i++)
        begin
            send_word(MODE_FILTER, {1'b0, {(SAMPLE_BITS-1){1'b1}}}, '0, '0, '0);
        end
        send_word(MODE_FLUSH, '0, '0, '0, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
        for (int i = 0; i < 4; i++)
        begin
            send_word(MODE_FILTER, '0, '0, '0, '0);
        end
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_TAP_COUNT, RATIO_BITS'(taps_set[ph]));
            write_reg(REG_DECIM_RATIO, RATIO_BITS'(ratio_set[ph]));
            if (ph == 1)
            begin
                hold_req = 1'b1;
            end
            if (ph == 5)
            begin
                calm = 1'b1;
            end
            random_words(words_set[ph]);
            drain();
        end

        if (fail_count == 0)
        begin
            $display("** decimating_fir_with_interpolation: PASSED **");
        end
        else
        begin
            $display("** decimating_fir_with_interpolation: FAILED **");
        end
        $finish;
    end

endmodule
